/* rtl/dsc_pkg.sv */
// ---------------------------------------------------------------------------
// dsc_pkg
// Types and constants for the five-point diffusion stencil coefficient block.
// ---------------------------------------------------------------------------
package dsc_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned ProdW        = 2 * DataW;
  localparam int unsigned NumW         = 3 * DataW + 1;
  localparam int unsigned DenW         = 2 * DataW + 1;
  localparam int unsigned EdgeDenW     = DataW + 3;
  localparam int unsigned SumW         = DataW + 3;
  localparam int unsigned NumSides     = 4;
  localparam int unsigned DivLat       = DataW + 2;

  localparam logic [DataW-1:0] MagLimit = {1'b1, {(DataW-1){1'b0}}};
  localparam logic [DataW-1:0] PosLimit = {1'b0, {(DataW-1){1'b1}}};

  typedef enum logic [1:0] {
    BND_VACUUM  = 2'd0,
    BND_REFLECT = 2'd1,
    BND_SOURCE  = 2'd2
  } bnd_kind_e;

  typedef enum logic [1:0] {
    CFG_LEFT   = 2'd0,
    CFG_RIGHT  = 2'd1,
    CFG_BOTTOM = 2'd2,
    CFG_TOP    = 2'd3
  } cfg_idx_e;

  localparam int unsigned SideLeft  = 0;
  localparam int unsigned SideRight = 1;
  localparam int unsigned SideBelow = 2;
  localparam int unsigned SideAbove = 3;

  typedef struct packed {
    logic [DataW-1:0] diff_center;
    logic [DataW-1:0] diff_left;
    logic [DataW-1:0] diff_right;
    logic [DataW-1:0] diff_below;
    logic [DataW-1:0] diff_above;
    logic [DataW-1:0] width_center;
    logic [DataW-1:0] width_left;
    logic [DataW-1:0] width_right;
    logic [DataW-1:0] height_center;
    logic [DataW-1:0] height_below;
    logic [DataW-1:0] height_above;
    logic [DataW-1:0] removal_xs;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] coef_left;
    logic signed [DataW-1:0] coef_right;
    logic signed [DataW-1:0] coef_below;
    logic signed [DataW-1:0] coef_above;
    logic signed [DataW-1:0] coef_center;
  } res_t;

endpackage

/* rtl/dsc_div.sv */
// ---------------------------------------------------------------------------
// dsc_div
// Pipelined restoring divider, one quotient bit per stage, saturating at 2^31.
// ---------------------------------------------------------------------------
module dsc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        vld_i,
  input  logic [dsc_pkg::NumW-1:0]    num_i,
  input  logic [dsc_pkg::DenW-1:0]    den_i,
  output logic                        vld_o,
  output logic [dsc_pkg::DataW-1:0]   mag_o
);

  localparam int unsigned W = dsc_pkg::DataW;
  localparam int unsigned D = dsc_pkg::DenW;

  logic [W:0]   vld_q;
  logic [D-1:0] rem_q  [W+1];
  logic [W-1:0] low_q  [W+1];
  logic [W-1:0] quo_q  [W+1];
  logic [D-1:0] den_q  [W+1];
  logic         zero_q [W+1];
  logic         sat_q  [W+1];
  logic [W-1:0] mag_q;
  logic         out_vld_q;

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= num_i[dsc_pkg::NumW-1:W];
    low_q[0]  <= num_i[W-1:0];
    quo_q[0]  <= '0;
    den_q[0]  <= den_i;
    zero_q[0] <= (num_i == '0);
    sat_q[0]  <= ({1'b0, num_i[dsc_pkg::NumW-1:W]} >= {1'b0, den_i});
  end

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [D:0]   rs;
    logic         ge;
    logic [D:0]   rn;
    assign rs = {rem_q[k], low_q[k][W-1]};
    assign ge = (rs >= {1'b0, den_q[k]});
    assign rn = ge ? (rs - {1'b0, den_q[k]}) : rs;
    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= rn[D-1:0];
      low_q[k+1]  <= {low_q[k][W-2:0], 1'b0};
      quo_q[k+1]  <= {quo_q[k][W-2:0], ge};
      den_q[k+1]  <= den_q[k];
      zero_q[k+1] <= zero_q[k];
      sat_q[k+1]  <= sat_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (zero_q[W]) begin
      mag_q <= '0;
    end else if (sat_q[W] || quo_q[W] > dsc_pkg::MagLimit) begin
      mag_q <= dsc_pkg::MagLimit;
    end else begin
      mag_q <= quo_q[W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[W-1:0], vld_i};
      out_vld_q <= vld_q[W];
    end
  end

  assign vld_o = out_vld_q;
  assign mag_o = mag_q;

endmodule

/* rtl/diffusion_stencil_coefficients.sv */
// ---------------------------------------------------------------------------
// diffusion_stencil_coefficients
// Five-point diffusion stencil entries for one mesh cell, Q fixed point.
// ---------------------------------------------------------------------------
// Pipeline: 3 input stages (multiplies, numerator forming), 34 divider stages and
// 1 summing stage from start to res_valid_o. Throughput: one cell per cycle; busy stays low.
// The divider's 32 quotient-bit stages set the latency.
// Reset clears all valid bits and sets every boundary kind to vacuum.
module diffusion_stencil_coefficients #(
  parameter int unsigned FRACTION_BITS = dsc_pkg::FracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  dsc_pkg::in_t              in_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_index_i,
  input  logic [1:0]                cfg_data_i,
  output logic                      res_valid_o,
  output dsc_pkg::res_t             res_o
);

  localparam int unsigned W  = dsc_pkg::DataW;
  localparam int unsigned P  = dsc_pkg::ProdW;
  localparam int unsigned NS = dsc_pkg::NumSides;
  localparam int unsigned RW = 3 * W;

  logic [1:0] bnd_q [NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) bnd_q[i] <= dsc_pkg::BND_VACUUM;
    end else if (cfg_valid_i) begin
      unique case (dsc_pkg::cfg_idx_e'(cfg_index_i))
        dsc_pkg::CFG_LEFT:   bnd_q[dsc_pkg::SideLeft]  <= cfg_data_i;
        dsc_pkg::CFG_RIGHT:  bnd_q[dsc_pkg::SideRight] <= cfg_data_i;
        dsc_pkg::CFG_BOTTOM: bnd_q[dsc_pkg::SideBelow] <= cfg_data_i;
        dsc_pkg::CFG_TOP:    bnd_q[dsc_pkg::SideAbove] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  // side operands: neighbor coefficient, neighbor size, face, own size
  logic [W-1:0] dn [NS];
  logic [W-1:0] hn [NS];
  logic [W-1:0] fc [NS];
  logic [W-1:0] hc [NS];

  always_comb begin
    dn[dsc_pkg::SideLeft]  = in_i.diff_left;
    hn[dsc_pkg::SideLeft]  = in_i.width_left;
    fc[dsc_pkg::SideLeft]  = in_i.height_center;
    hc[dsc_pkg::SideLeft]  = in_i.width_center;
    dn[dsc_pkg::SideRight] = in_i.diff_right;
    hn[dsc_pkg::SideRight] = in_i.width_right;
    fc[dsc_pkg::SideRight] = in_i.height_center;
    hc[dsc_pkg::SideRight] = in_i.width_center;
    dn[dsc_pkg::SideBelow] = in_i.diff_below;
    hn[dsc_pkg::SideBelow] = in_i.height_below;
    fc[dsc_pkg::SideBelow] = in_i.width_center;
    hc[dsc_pkg::SideBelow] = in_i.height_center;
    dn[dsc_pkg::SideAbove] = in_i.diff_above;
    hn[dsc_pkg::SideAbove] = in_i.height_above;
    fc[dsc_pkg::SideAbove] = in_i.width_center;
    hc[dsc_pkg::SideAbove] = in_i.height_center;
  end

  logic        v1_q, v2_q, v3_q;
  logic [P-1:0] wh1_q;
  logic [W-1:0] sr1_q;
  logic [P-1:0] rl2_q, rh2_q;
  logic [W:0]   rem3_q;

  logic [NS-1:0]            dvld;
  logic [W-1:0]             mag   [NS];
  logic [NS-1:0]            edge3;

  for (genvar s = 0; s < NS; s++) begin : g_side
    logic [P-1:0]                   a1_q, b1_q, c1_q, e1_q;
    logic [dsc_pkg::EdgeDenW-1:0]   eden1_q;
    logic [W-1:0]                   face1_q;
    logic                           edge1_q, vac1_q;
    logic [P-1:0]                   pl2_q, ph2_q, e2_q;
    logic [dsc_pkg::DenW-1:0]       den2_q;
    logic                           edge2_q, vac2_q;
    logic [dsc_pkg::NumW-1:0]       num3_q;
    logic [dsc_pkg::DenW-1:0]       den3_q;
    logic                           edge3_q;
    logic [dsc_pkg::NumW-2:0]       cprod;
    logic [dsc_pkg::NumW-1:0]       cnum;

    always_ff @(posedge clk_i) begin
      a1_q    <= P'(dn[s]) * P'(in_i.diff_center);
      b1_q    <= P'(hn[s]) * P'(in_i.diff_center);
      c1_q    <= P'(hc[s]) * P'(dn[s]);
      e1_q    <= P'(in_i.diff_center) * P'(fc[s]);
      eden1_q <= {in_i.diff_center, 2'b00} + dsc_pkg::EdgeDenW'(hc[s]);
      face1_q <= fc[s];
      edge1_q <= (dn[s] == '0);
      vac1_q  <= (bnd_q[s] != dsc_pkg::BND_REFLECT);

      pl2_q   <= P'(a1_q[W-1:0]) * P'(face1_q);
      ph2_q   <= P'(a1_q[P-1:W]) * P'(face1_q);
      e2_q    <= e1_q;
      den2_q  <= edge1_q ? dsc_pkg::DenW'(eden1_q)
                         : ({1'b0, b1_q} + {1'b0, c1_q});
      edge2_q <= edge1_q;
      vac2_q  <= vac1_q;

      num3_q  <= edge2_q ? (vac2_q ? {{(W){1'b0}}, e2_q, 1'b0} : '0) : cnum;
      den3_q  <= den2_q;
      edge3_q <= edge2_q;
    end

    assign cprod    = {ph2_q, {(W){1'b0}}} + (dsc_pkg::NumW-1)'(pl2_q);
    assign cnum     = {cprod, 1'b0};
    assign edge3[s] = edge3_q;

    dsc_div u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (v3_q),
      .num_i  (num3_q),
      .den_i  (den3_q),
      .vld_o  (dvld[s]),
      .mag_o  (mag[s])
    );
  end

  logic [RW-1:0] rprod;
  logic [RW-1:0] rshift;
  assign rprod  = {rh2_q, {(W){1'b0}}} + RW'(rl2_q);
  assign rshift = rprod >> (2 * FRACTION_BITS);

  always_ff @(posedge clk_i) begin
    wh1_q  <= P'(in_i.width_center) * P'(in_i.height_center);
    sr1_q  <= in_i.removal_xs;
    rl2_q  <= P'(wh1_q[W-1:0]) * P'(sr1_q);
    rh2_q  <= P'(wh1_q[P-1:W]) * P'(sr1_q);
    rem3_q <= (rshift > RW'(dsc_pkg::MagLimit)) ? {1'b0, dsc_pkg::MagLimit}
                                                 : rshift[W:0];
  end

  // delay removal term and edge flags alongside the dividers
  logic [W:0]    rem_dly_q  [dsc_pkg::DivLat];
  logic [NS-1:0] edge_dly_q [dsc_pkg::DivLat];

  always_ff @(posedge clk_i) begin
    rem_dly_q[0]  <= rem3_q;
    edge_dly_q[0] <= edge3;
    for (int i = 1; i < dsc_pkg::DivLat; i++) begin
      rem_dly_q[i]  <= rem_dly_q[i-1];
      edge_dly_q[i] <= edge_dly_q[i-1];
    end
  end

  logic [dsc_pkg::SumW-1:0] sum;
  logic [NS-1:0]            edg;
  assign edg = edge_dly_q[dsc_pkg::DivLat-1];
  assign sum = dsc_pkg::SumW'(rem_dly_q[dsc_pkg::DivLat-1])
             + dsc_pkg::SumW'(mag[0]) + dsc_pkg::SumW'(mag[1])
             + dsc_pkg::SumW'(mag[2]) + dsc_pkg::SumW'(mag[3]);

  logic          res_vld_q;
  dsc_pkg::res_t res_q;

  always_ff @(posedge clk_i) begin
    res_q.coef_left   <= edg[dsc_pkg::SideLeft]  ? '0 : -mag[dsc_pkg::SideLeft];
    res_q.coef_right  <= edg[dsc_pkg::SideRight] ? '0 : -mag[dsc_pkg::SideRight];
    res_q.coef_below  <= edg[dsc_pkg::SideBelow] ? '0 : -mag[dsc_pkg::SideBelow];
    res_q.coef_above  <= edg[dsc_pkg::SideAbove] ? '0 : -mag[dsc_pkg::SideAbove];
    res_q.coef_center <= (sum > dsc_pkg::SumW'(dsc_pkg::PosLimit)) ? dsc_pkg::PosLimit
                                                                   : sum[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      v1_q      <= start;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      res_vld_q <= &dvld;
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule
